@@ sv/sraf_pkg.sv @@
// ----------------------------------------------------------------------------
// Spike-rejecting average filter package
// Shared constants, payload types, register indexes, verdict codes and the
// sequencer state type.
// ----------------------------------------------------------------------------
package sraf_pkg;

  localparam int WINDOW_LEN = 5;

  localparam int SAMPLE_W   = 16;
  localparam int TIME_W     = 32;
  localparam int THR_W      = 16;
  localparam int SUM_W      = 20;
  localparam int SLOT_W     = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int CNT_W      = $clog2(WINDOW_LEN + 1);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic        [TIME_W-1:0]   time_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic        [CNT_W-1:0]    count_t;
  typedef logic        [SLOT_W-1:0]   slot_t;

  typedef enum logic [1:0] {
    VERD_FIRST   = 2'd0,
    VERD_MEAN    = 2'd1,
    VERD_HELD    = 2'd2,
    VERD_EXTREME = 2'd3
  } verdict_t;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOLERANCE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TIMEOUT   = 2'd2;

  localparam logic [THR_W-1:0] THRESHOLD_RESET = 16'd300;
  localparam logic [THR_W-1:0] TOLERANCE_RESET = 16'd50;
  localparam time_t            TIMEOUT_RESET   = 32'd60000;

  typedef struct packed {
    logic [THR_W-1:0] change_threshold;
    logic [THR_W-1:0] match_tolerance;
    time_t            persist_timeout;
  } cfg_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } ring_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_WRITE,
    ST_START,
    ST_WAIT,
    ST_DECIDE
  } state_t;

endpackage

@@ sv/sraf_if.sv @@
// ----------------------------------------------------------------------------
// Spike-rejecting average filter channel interfaces
// Valid/ready channels for samples, results and configuration writes.
// ----------------------------------------------------------------------------
interface sraf_in_if;
  import sraf_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample;
  time_t   now_ms;

  modport source (output valid, output sample, output now_ms, input ready);
  modport sink   (input valid, input sample, input now_ms, output ready);
endinterface

interface sraf_out_if;
  import sraf_pkg::*;

  logic     valid;
  logic     ready;
  sample_t  filtered;
  verdict_t verdict;

  modport source (output valid, output filtered, output verdict, input ready);
  modport sink   (input valid, input filtered, input verdict, output ready);
endinterface

interface sraf_cfg_if;
  import sraf_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ sv/sraf_ring.sv @@
// ----------------------------------------------------------------------------
// Sample ring
// Window memory of recent samples with write pointer, fill flag and a
// running sum; reports the sum and the number of samples in the window.
// ----------------------------------------------------------------------------
module sraf_ring (
  input  logic                clk,
  input  logic                rst_n,
  input  sraf_pkg::ring_ctl_t ctl,
  input  sraf_pkg::sample_t   sample,
  output sraf_pkg::sum_t      sum,
  output sraf_pkg::count_t    count
);
  import sraf_pkg::*;

  sample_t mem [WINDOW_LEN];
  sample_t rd_data_r;
  slot_t   slot_r;
  logic    full_r;
  sum_t    sum_r;
  sum_t    sum_nxt;
  sum_t    old_ext;

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data_r <= mem[slot_r];
    end
    if (ctl.wr_en) begin
      mem[slot_r] <= sample;
    end
  end

  always_comb begin
    old_ext = full_r ? sum_t'(rd_data_r) : '0;
    sum_nxt = sum_r - old_ext + sum_t'(sample);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
      full_r <= 1'b0;
      sum_r  <= '0;
    end else if (ctl.wr_en) begin
      sum_r <= sum_nxt;
      if (slot_r == slot_t'(WINDOW_LEN - 1)) begin
        slot_r <= '0;
        full_r <= 1'b1;
      end else begin
        slot_r <= slot_r + slot_t'(1);
      end
    end
  end

  assign sum   = sum_r;
  assign count = full_r ? count_t'(WINDOW_LEN) : count_t'(slot_r);

endmodule

@@ sv/sraf_div.sv @@
// ----------------------------------------------------------------------------
// Iterative mean divider
// Restoring divider, one quotient bit per cycle, that divides the signed
// window sum by the sample count and truncates toward zero.
// ----------------------------------------------------------------------------
module sraf_div (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  sraf_pkg::sum_t    dividend,
  input  sraf_pkg::count_t  divisor,
  output logic              done,
  output sraf_pkg::sample_t quotient
);
  import sraf_pkg::*;

  localparam int STEP_W = $clog2(SUM_W);

  logic [SUM_W-1:0]  q_r;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  div_r;
  logic [STEP_W-1:0] step_r;
  logic              neg_r;
  logic              busy_r;
  logic              done_r;
  logic [CNT_W:0]    rem_sh;
  logic [CNT_W:0]    rem_diff;
  logic              fits;
  logic [SUM_W-1:0]  q_signed;

  always_comb begin
    rem_sh   = {rem_r, q_r[SUM_W-1]};
    rem_diff = rem_sh - {1'b0, div_r};
    fits     = (rem_sh >= {1'b0, div_r});
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[SUM_W-1];
      q_r   <= dividend[SUM_W-1] ? (-dividend) : dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[SUM_W-2:0], fits};
      rem_r <= fits ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (busy_r) begin
      if (step_r == STEP_W'(SUM_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end else begin
        step_r <= step_r + STEP_W'(1);
        done_r <= 1'b0;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  assign q_signed = neg_r ? (-q_r) : q_r;
  assign quotient = q_signed[SAMPLE_W-1:0];
  assign done     = done_r;

endmodule

@@ sv/sraf_ctrl.sv @@
// ----------------------------------------------------------------------------
// Filter sequencer and decision logic
// Steps one sample through ring update and division, then applies the
// spike rejection rules and loads the result register.
// ----------------------------------------------------------------------------
module sraf_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sraf_pkg::cfg_t       cfg,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sraf_pkg::sample_t    in_sample,
  input  sraf_pkg::time_t      in_now_ms,
  output sraf_pkg::ring_ctl_t  ring_ctl,
  output sraf_pkg::sample_t    ring_sample,
  output logic                 div_start,
  input  logic                 div_done,
  input  sraf_pkg::sample_t    mean,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sraf_pkg::sample_t    out_filtered,
  output sraf_pkg::verdict_t   out_verdict
);
  import sraf_pkg::*;

  state_t   state_r;
  state_t   state_nxt;
  logic     commit;

  sample_t  sample_r;
  time_t    now_r;
  sample_t  held_r;
  logic     held_valid_r;
  sample_t  ext_r;
  logic     ext_valid_r;
  time_t    since_r;
  logic     out_valid_r;
  sample_t  filt_r;
  verdict_t verd_r;

  logic signed [SAMPLE_W:0] diff_h;
  logic signed [SAMPLE_W:0] diff_e;
  logic        [SAMPLE_W:0] abs_h;
  logic        [SAMPLE_W:0] abs_e;
  time_t                    elapsed;
  logic                     jump;
  logic                     match;
  logic                     expired;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_READ;
      ST_READ:   state_nxt = ST_WRITE;
      ST_WRITE:  state_nxt = ST_START;
      ST_START:  state_nxt = ST_WAIT;
      ST_WAIT:   if (div_done) state_nxt = ST_DECIDE;
      ST_DECIDE: if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    ring_ctl.rd_en = 1'b0;
    ring_ctl.wr_en = 1'b0;
    div_start      = 1'b0;
    commit         = 1'b0;
    unique case (state_r)
      ST_IDLE:   in_ready = 1'b1;
      ST_READ:   ring_ctl.rd_en = 1'b1;
      ST_WRITE:  ring_ctl.wr_en = 1'b1;
      ST_START:  div_start = 1'b1;
      ST_WAIT:   ;
      ST_DECIDE: commit = !out_valid_r || out_ready;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sample_r <= in_sample;
      now_r    <= in_now_ms;
    end
  end

  always_comb begin
    diff_h  = {sample_r[SAMPLE_W-1], sample_r} - {held_r[SAMPLE_W-1], held_r};
    diff_e  = {sample_r[SAMPLE_W-1], sample_r} - {ext_r[SAMPLE_W-1], ext_r};
    abs_h   = diff_h[SAMPLE_W] ? (-diff_h) : diff_h;
    abs_e   = diff_e[SAMPLE_W] ? (-diff_e) : diff_e;
    elapsed = now_r - since_r;
    jump    = abs_h > {1'b0, cfg.change_threshold};
    match   = ext_valid_r && (abs_e < {1'b0, cfg.match_tolerance});
    expired = elapsed > cfg.persist_timeout;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r       <= '0;
      held_valid_r <= 1'b0;
      ext_r        <= '0;
      ext_valid_r  <= 1'b0;
      since_r      <= '0;
    end else if (commit) begin
      priority if (!held_valid_r) begin
        held_r       <= mean;
        held_valid_r <= 1'b1;
      end else if (jump) begin
        if (match) begin
          if (expired) begin
            held_r      <= sample_r;
            ext_r       <= '0;
            ext_valid_r <= 1'b0;
            since_r     <= '0;
          end
        end else begin
          ext_r       <= sample_r;
          ext_valid_r <= 1'b1;
          since_r     <= now_r;
        end
      end else begin
        held_r      <= mean;
        ext_r       <= '0;
        ext_valid_r <= 1'b0;
        since_r     <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      priority if (!held_valid_r) begin
        filt_r <= mean;
        verd_r <= VERD_FIRST;
      end else if (jump) begin
        if (match && expired) begin
          filt_r <= sample_r;
          verd_r <= VERD_EXTREME;
        end else begin
          filt_r <= held_r;
          verd_r <= VERD_HELD;
        end
      end else begin
        filt_r <= mean;
        verd_r <= VERD_MEAN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign ring_sample  = sample_r;
  assign out_valid    = out_valid_r;
  assign out_filtered = filt_r;
  assign out_verdict  = verd_r;

endmodule

@@ sv/spike_rejecting_average_filter.sv @@
// ----------------------------------------------------------------------------
// Spike-rejecting average filter
// Moving average over a short sample window with rejection of sudden jumps
// and acceptance of extremes that persist beyond a timeout.
// ----------------------------------------------------------------------------
// Usage:
// A sample and its millisecond timestamp enter on in_ch as one transaction.
// Exactly one result (filtered value and verdict) leaves on out_ch for each
// sample. The configuration port cfg_ch is always ready; index 0 writes the
// change threshold, 1 the match tolerance and 2 the persist timeout. Other
// indexes are ignored. Write registers only while the filter is idle.
// After a sample is accepted, the sequencer runs one ring read, one ring
// write, one divider load, the 20-step restoring divider that forms the
// window mean, a wait for the divider to finish and one decision step.
// The filter takes no new sample until that decision step has loaded the
// result register.
// Reset clears the window fill state, the running sum, the held and extreme
// tracking and restores the register defaults (300, 50, 60000).
// A result waits in the output register while the receiver stalls, and the
// next sample is still taken and processed; it then waits in the decision
// step until the output register is free.
// ----------------------------------------------------------------------------
module spike_rejecting_average_filter (
  input logic clk,
  input logic rst_n,
  sraf_in_if.sink     in_ch,
  sraf_out_if.source  out_ch,
  sraf_cfg_if.sink    cfg_ch
);
  import sraf_pkg::*;

  cfg_t      cfg_r;
  ring_ctl_t ring_ctl;
  sample_t   ring_sample;
  sum_t      ring_sum;
  count_t    ring_count;
  logic      div_start;
  logic      div_done;
  sample_t   mean;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.change_threshold <= THRESHOLD_RESET;
      cfg_r.match_tolerance  <= TOLERANCE_RESET;
      cfg_r.persist_timeout  <= TIMEOUT_RESET;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == CFG_IDX_THRESHOLD) begin
        cfg_r.change_threshold <= cfg_ch.data[THR_W-1:0];
      end
      if (cfg_ch.index == CFG_IDX_TOLERANCE) begin
        cfg_r.match_tolerance <= cfg_ch.data[THR_W-1:0];
      end
      if (cfg_ch.index == CFG_IDX_TIMEOUT) begin
        cfg_r.persist_timeout <= cfg_ch.data[TIME_W-1:0];
      end
    end
  end

  sraf_ring u_ring (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ring_ctl),
    .sample (ring_sample),
    .sum    (ring_sum),
    .count  (ring_count)
  );

  sraf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (ring_sum),
    .divisor  (ring_count),
    .done     (div_done),
    .quotient (mean)
  );

  sraf_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_sample    (in_ch.sample),
    .in_now_ms    (in_ch.now_ms),
    .ring_ctl     (ring_ctl),
    .ring_sample  (ring_sample),
    .div_start    (div_start),
    .div_done     (div_done),
    .mean         (mean),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_filtered (out_ch.filtered),
    .out_verdict  (out_ch.verdict)
  );

endmodule

@@ sv/sraf_checker.sv @@
// ----------------------------------------------------------------------------
// Spike-rejecting average filter checker
// Port-level assertions on handshakes, busy time and reset behavior.
// ----------------------------------------------------------------------------
module sraf_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input sraf_pkg::sample_t  out_filtered,
  input sraf_pkg::verdict_t out_verdict
);
  import sraf_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("Result withdrawn before its transaction completed.");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_filtered) && $stable(out_verdict))
    else $error("Result payload changed while stalled.");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("Input taken again while a sample is being processed.");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result valid right after reset.");

  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("Result appeared without a sample in progress.");

endmodule

bind spike_rejecting_average_filter sraf_checker u_sraf_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_filtered (out_ch.filtered),
  .out_verdict  (out_ch.verdict)
);

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// Spike-rejecting average filter testbench
// Drives timestamped samples into the filter and compares every result with a
// cycle-free model of the window mean, jump rejection and extreme acceptance.
// A short table of directed samples runs first at the reset register values.
// Six random phases follow, each with its own register setting, the extremes
// among them. Both channels idle at random, and the receiver stalls once for
// a long stretch so that the filter backs up into its input.
// ----------------------------------------------------------------------------
module tb_top;
  import sraf_pkg::*;

  localparam int N_DIRECTED    = 18;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_AT       = 500;
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_LIMIT   = 20000;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

  typedef struct packed {
    sample_t  filtered;
    verdict_t verdict;
  } filter_result_t;

  typedef struct packed {
    sample_t  sample;
    time_t    now_ms;
    logic     known;
    sample_t  filtered;
    verdict_t verdict;
  } stim_row_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  sraf_in_if  in_ch ();
  sraf_out_if out_ch ();
  sraf_cfg_if cfg_ch ();

  spike_rejecting_average_filter dut (
    .clk,
    .rst_n,
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #5 clk = ~clk;

  // Filter model state and register copies.
  sample_t          win_buf [WINDOW_LEN];
  int               win_pos;
  bit               win_full;
  int               win_sum;
  int               acc_value;
  bit               acc_valid;
  int               peak_value;
  bit               peak_valid;
  time_t            peak_since;
  logic [THR_W-1:0] thr_reg;
  logic [THR_W-1:0] tol_reg;
  time_t            tmo_reg;

  filter_result_t pending_results [$];
  int             mismatches   = 0;
  int             results_seen = 0;
  bit             steady_mode  = 1'b0;
  int             level        = 0;
  time_t          clock_ms     = '0;

  stim_row_t directed_rows [N_DIRECTED] = '{
    '{16'sd100,    32'd0,          1'b1, 16'sd100,    VERD_FIRST},
    '{16'sd32767,  32'd1000,       1'b1, 16'sd100,    VERD_HELD},
    '{16'sd32760,  32'd2000,       1'b1, 16'sd100,    VERD_HELD},
    '{16'sd32750,  32'd70000,      1'b1, 16'sd32750,  VERD_EXTREME},
    '{-16'sd32768, 32'd70001,      1'b1, 16'sd32750,  VERD_HELD},
    '{-16'sd32768, 32'd130001,     1'b1, 16'sd32750,  VERD_HELD},
    '{-16'sd32768, 32'd130002,     1'b1, -16'sd32768, VERD_EXTREME},
    '{-16'sd32600, 32'd130003,     1'b0, 16'sd0,      VERD_FIRST},
    '{16'sd20000,  32'hFFFF_FF00,  1'b0, 16'sd0,      VERD_FIRST},
    '{16'sd20010,  32'h0000_F000,  1'b0, 16'sd0,      VERD_FIRST},
    '{16'sd20100,  32'h0000_F100,  1'b0, 16'sd0,      VERD_FIRST},
    '{-16'sd750,   32'h0000_F200,  1'b0, 16'sd0,      VERD_FIRST},
    '{-16'sd1351,  32'h0000_F300,  1'b0, 16'sd0,      VERD_FIRST},
    '{16'sd10000,  32'd65536,      1'b0, 16'sd0,      VERD_FIRST},
    '{16'sd10050,  32'd135536,     1'b0, 16'sd0,      VERD_FIRST},
    '{16'sd10049,  32'd205537,     1'b0, 16'sd0,      VERD_FIRST},
    '{16'sd0,      32'hFFFF_FFFF,  1'b0, 16'sd0,      VERD_FIRST},
    '{-16'sd1,     32'hFFFF_FFFF,  1'b0, 16'sd0,      VERD_FIRST}
  };

  task automatic clear_filter_model();
    for (int i = 0; i < WINDOW_LEN; i++) win_buf[i] = '0;
    win_pos    = 0;
    win_full   = 1'b0;
    win_sum    = 0;
    acc_value  = 0;
    acc_valid  = 1'b0;
    peak_value = 0;
    peak_valid = 1'b0;
    peak_since = '0;
    thr_reg    = THRESHOLD_RESET;
    tol_reg    = TOLERANCE_RESET;
    tmo_reg    = TIMEOUT_RESET;
  endtask

  function automatic int abs_gap(input int a, input int b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic filter_result_t compute_filter_output(input sample_t s, input time_t now);
    int             cnt;
    int             mean;
    int             res;
    time_t          elapsed;
    verdict_t       v;
    filter_result_t r;
    if (win_full) win_sum -= win_buf[win_pos];
    win_buf[win_pos] = s;
    win_sum += s;
    win_pos++;
    if (win_pos >= WINDOW_LEN) begin
      win_pos  = 0;
      win_full = 1'b1;
    end
    cnt  = win_full ? WINDOW_LEN : win_pos;
    mean = win_sum / cnt;
    if (!acc_valid) begin
      acc_value = mean;
      acc_valid = 1'b1;
      res       = mean;
      v         = VERD_FIRST;
    end else if (abs_gap(s, acc_value) > int'(thr_reg)) begin
      res = acc_value;
      v   = VERD_HELD;
      if (peak_valid && abs_gap(s, peak_value) < int'(tol_reg)) begin
        elapsed = now - peak_since;
        if (elapsed > tmo_reg) begin
          acc_value  = s;
          peak_valid = 1'b0;
          peak_value = 0;
          peak_since = '0;
          res        = s;
          v          = VERD_EXTREME;
        end
      end else begin
        peak_value = s;
        peak_valid = 1'b1;
        peak_since = now;
      end
    end else begin
      acc_value  = mean;
      peak_valid = 1'b0;
      peak_value = 0;
      peak_since = '0;
      res        = mean;
      v          = VERD_MEAN;
    end
    r.filtered = sample_t'(res);
    r.verdict  = v;
    return r;
  endfunction

  function automatic int clamp_level(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  task automatic offer_sample(input sample_t s, input time_t t, input bit known,
                              input filter_result_t typed);
    filter_result_t pred;
    while (!steady_mode && $urandom_range(99, 0) < 35) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.sample <= s;
    in_ch.now_ms <= t;
    do @(posedge clk); while (!in_ch.ready);
    pred = compute_filter_output(s, t);
    pending_results.push_back(known ? typed : pred);
  endtask

  task automatic settle_filter();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      CFG_IDX_THRESHOLD: thr_reg = data[THR_W-1:0];
      CFG_IDX_TOLERANCE: tol_reg = data[THR_W-1:0];
      CFG_IDX_TIMEOUT:   tmo_reg = data;
      default: ;
    endcase
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_random_phase(input int n_items);
    int    left;
    int    kind;
    int    run_len;
    int    span;
    int    jit;
    int    peak;
    int    sgn;
    time_t t0;
    time_t off;
    left = n_items;
    while (left > 0) begin
      kind = $urandom_range(99, 0);
      span = (thr_reg > 16'd8000) ? 2000 : int'(thr_reg) / 4;
      sgn  = ($urandom_range(1, 0) == 0) ? 1 : -1;
      if (kind < 45) begin
        run_len = $urandom_range(12, 1);
        for (int k = 0; k < run_len && left > 0; k++) begin
          level    = clamp_level(level + int'($urandom_range(2 * span, 0)) - span);
          clock_ms = clock_ms + time_t'($urandom_range(5000, 200));
          offer_sample(sample_t'(clamp_level(level + int'($urandom_range(span, 0)) - span / 2)),
                       clock_ms, 1'b0, '0);
          left--;
        end
      end else if (kind < 60) begin
        clock_ms = clock_ms + time_t'($urandom_range(5000, 200));
        offer_sample(sample_t'(clamp_level(level + sgn * (int'(thr_reg) + 1 +
                                                       int'($urandom_range(6000, 0))))),
                     clock_ms, 1'b0, '0);
        left--;
      end else if (kind < 88) begin
        peak = clamp_level(level + sgn * (int'(thr_reg) + 1 + int'($urandom_range(8000, 0))));
        jit  = (tol_reg > 16'd1) ? (int'(tol_reg) - 1) / 2 : 0;
        if (jit > 1000) jit = 1000;
        run_len  = $urandom_range(8, 3);
        clock_ms = clock_ms + time_t'($urandom_range(5000, 200));
        t0       = clock_ms;
        off      = '0;
        for (int k = 0; k < run_len && left > 0; k++) begin
          if (k == run_len - 1) off = tmo_reg + time_t'($urandom_range(3, 0)) - 1;
          else off = time_t'((longint'(tmo_reg) * k) / (run_len - 1));
          offer_sample(sample_t'(clamp_level(peak + int'($urandom_range(2 * jit, 0)) - jit)),
                       t0 + off, 1'b0, '0);
          left--;
        end
        clock_ms = t0 + off;
        if ($urandom_range(1, 0) == 1) level = peak;
      end else begin
        t0 = $urandom;
        if ($urandom_range(1, 0) == 1) clock_ms = t0;
        offer_sample(sample_t'($urandom), t0, 1'b0, '0);
        left--;
      end
    end
  endtask

  // Result checker and receiver-side flow control.
  initial begin
    filter_result_t want;
    int             hold_left;
    bit             hold_done;
    hold_left    = 0;
    hold_done    = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected result transaction: filtered %0d verdict %0d",
                     out_ch.filtered, out_ch.verdict);
        end else begin
          want = pending_results.pop_front();
          if (out_ch.filtered !== want.filtered || out_ch.verdict !== want.verdict) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Result %0d mismatch: expected filtered %0d verdict %0d, got %0d / %0d",
                       results_seen, want.filtered, want.verdict,
                       out_ch.filtered, out_ch.verdict);
          end
        end
        results_seen++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= steady_mode || ($urandom_range(99, 0) >= 35);
      end
    end
  end

  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int guard;
    in_ch.valid  = 1'b0;
    in_ch.sample = '0;
    in_ch.now_ms = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_IDX_THRESHOLD;
    cfg_ch.data  = '0;
    clear_filter_model();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++)
      offer_sample(directed_rows[i].sample, directed_rows[i].now_ms, directed_rows[i].known,
                   '{directed_rows[i].filtered, directed_rows[i].verdict});
    level    = -1000;
    clock_ms = 32'd300000;

    for (int phase = 0; phase < 6; phase++) begin
      settle_filter();
      steady_mode = (phase == 0);
      case (phase)
        0: begin
          write_reg(CFG_IDX_THRESHOLD, 32'd300);
          write_reg(CFG_IDX_TOLERANCE, 32'd50);
          write_reg(CFG_IDX_TIMEOUT, 32'd60000);
        end
        1: begin
          write_reg(CFG_IDX_THRESHOLD, 32'd0);
          write_reg(CFG_IDX_TOLERANCE, 32'd0);
          write_reg(CFG_IDX_TIMEOUT, 32'd0);
        end
        2: begin
          write_reg(CFG_IDX_THRESHOLD, {16'($urandom_range(16'hFFFF, 0)), 16'hFFFF});
          write_reg(CFG_IDX_TOLERANCE, 32'hFFFF_FFFF);
          write_reg(CFG_IDX_TIMEOUT, 32'hFFFF_FFFF);
          clock_ms = 32'hFFF0_0000;
        end
        3: begin
          write_reg(CFG_IDX_THRESHOLD, $urandom_range(1000, 0));
          write_reg(CFG_IDX_TOLERANCE, $urandom_range(300, 1));
          write_reg(CFG_IDX_TIMEOUT, $urandom_range(100000, 0));
        end
        4: begin
          write_reg(CFG_IDX_THRESHOLD, 32'd200);
          write_reg(CFG_IDX_TOLERANCE, 32'd65535);
          write_reg(CFG_IDX_TIMEOUT, 32'd0);
        end
        default: begin
          write_reg(CFG_IDX_UNUSED, $urandom);
          write_reg(CFG_IDX_THRESHOLD, $urandom);
          write_reg(CFG_IDX_TOLERANCE, $urandom);
          write_reg(CFG_IDX_TIMEOUT, $urandom);
        end
      endcase
      run_random_phase((phase == 5) ? 300 : 270);
    end

    in_ch.valid <= 1'b0;
    guard = 0;
    while (pending_results.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    if (pending_results.size() != 0) begin
      mismatches += pending_results.size();
      $display("%0d expected results never arrived", pending_results.size());
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/sraf_pkg.sv
sv/sraf_if.sv
sv/sraf_ring.sv
sv/sraf_div.sv
sv/sraf_ctrl.sv
sv/spike_rejecting_average_filter.sv
sv/sraf_checker.sv
sim/tb_top.sv
